>>> hdl/plti_pkg.sv
// Shared types and constants for the piecewise-linear table interpolator.
// Used by the channel interfaces, the table cells, the divider and the top level.
package plti_pkg;

  localparam int EFF_W  = 15;
  localparam int QUOT_W = 15;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

endpackage

>>> hdl/plti_if.sv
// Valid/ready channel interfaces for the table interpolator's input and result beats.
// Depends on plti_pkg for the efficiency width.
interface plti_in_if import plti_pkg::*; #(
  parameter int WB = 16
) ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [WB-1:0]    wavelength;
  logic [EFF_W-1:0] efficiency_in;

  modport source (output valid, action, wavelength, efficiency_in, input ready);
  modport sink   (input valid, action, wavelength, efficiency_in, output ready);
endinterface

interface plti_out_if import plti_pkg::*; #(
  parameter int WB = 16,
  parameter int CW = 7
) ();
  logic             valid;
  logic             ready;
  logic [EFF_W-1:0] efficiency_out;
  logic             below_range;
  logic             above_range;
  logic             table_empty;
  logic             load_refused;
  logic [WB-1:0]    lowest_wavelength;
  logic [WB-1:0]    highest_wavelength;
  logic [CW-1:0]    point_count;

  modport source (output valid, efficiency_out, below_range, above_range, table_empty,
                  load_refused, lowest_wavelength, highest_wavelength, point_count,
                  input ready);
  modport sink   (input valid, efficiency_out, below_range, above_range, table_empty,
                  load_refused, lowest_wavelength, highest_wavelength, point_count,
                  output ready);
endinterface

>>> hdl/plti_cell.sv
// One table cell: holds a single wavelength/efficiency point of the sorted chain.
// Depends on plti_pkg for the cell control struct and efficiency width.
module plti_cell import plti_pkg::*; #(
  parameter int WB  = 16,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CW-1:0]    count,
  input  logic [WB-1:0]    new_key,
  input  logic [EFF_W-1:0] new_eff,
  input  logic [WB-1:0]    left_key,
  input  logic [EFF_W-1:0] left_eff,
  input  logic             left_keep,
  input  logic [WB-1:0]    right_key,
  input  logic [EFF_W-1:0] right_eff,
  output logic [WB-1:0]    key_r,
  output logic [EFF_W-1:0] eff_r,
  output logic             keep
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic          FIRST = (IDX == 0);

  logic             occupied;
  logic             take_new;
  logic [WB-1:0]    key_nxt;
  logic [EFF_W-1:0] eff_nxt;

  // A cell keeps its point when the new key sorts after it (ties go after).
  assign occupied = (IDX_C < count);
  assign keep     = occupied && (key_r <= new_key);
  assign take_new = !keep && (left_keep || FIRST);

  always_comb begin
    key_nxt = key_r;
    eff_nxt = eff_r;
    if (ctrl.rotate) begin
      key_nxt = right_key;
      eff_nxt = right_eff;
    end else if (ctrl.insert && !keep) begin
      if (take_new) begin
        key_nxt = new_key;
        eff_nxt = new_eff;
      end else begin
        key_nxt = left_key;
        eff_nxt = left_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    eff_r <= eff_nxt;
  end

endmodule

>>> hdl/plti_div.sv
// Restoring divider that produces a quotient known to fit QUOT_W bits, one bit a cycle.
// Depends on plti_pkg for the quotient and efficiency widths.
module plti_div import plti_pkg::*; #(
  parameter int WB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WB+EFF_W-1:0]   prod,
  input  logic [WB-1:0]         den,
  output logic                  done,
  output logic [QUOT_W-1:0]     quot
);

  localparam int NCW = $clog2(QUOT_W + 1);

  logic [WB-1:0]     rem_r;
  logic [QUOT_W-1:0] sh_r;
  logic [QUOT_W-1:0] quot_r;
  logic [NCW-1:0]    cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WB:0]       trial;
  logic              fits;

  assign trial = {rem_r, sh_r[QUOT_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= prod[WB+EFF_W-1:QUOT_W];
        sh_r   <= prod[QUOT_W-1:0];
        quot_r <= '0;
        cnt_r  <= NCW'(QUOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? WB'(trial - {1'b0, den}) : trial[WB-1:0];
        sh_r   <= {sh_r[QUOT_W-2:0], 1'b0};
        quot_r <= {quot_r[QUOT_W-2:0], fits};
        cnt_r  <= cnt_r - NCW'(1);
        if (cnt_r == NCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> hdl/piecewise_linear_table_interp_top.sv
// Piecewise-linear efficiency table: the chain of point cells, the rotation scan and the divider.
// Depends on plti_pkg, plti_if, plti_cell and plti_div.
//
// Usage: beats enter on in_if (action, wavelength, efficiency_in) and each one yields exactly
// one result beat on out_if. Clear, load and no-op beats, and queries that clamp to an end
// of the table or find it empty, give their result in the cycle after acceptance. A query that
// falls strictly inside the table goes through these steps: the chain of cells rotates
// once all the way round while the bracketing pair is picked off at the head, then the
// multiply, the divider start, the divider's QUOT_W quotient bits, the wait to see the
// divider finish, and the result write.
// A load inserts its point as it is accepted: each cell either keeps its point, takes the new one
// or takes its left neighbor's. One beat is worked on at a time; in_if.ready is high in the
// idle state while the result register is empty or being emptied.
// Reset empties the table at once (the point count is cleared); cell contents need no reset.
// When the receiver stalls, the result beat holds in the output register and no new beat is
// taken until it leaves.
module piecewise_linear_table_interp_top import plti_pkg::*; #(
  parameter int MAX_POINTS      = 64,
  parameter int WAVELENGTH_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  plti_in_if.sink    in_if,
  plti_out_if.source out_if
);

  localparam int WB = WAVELENGTH_BITS;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int PW = WB + EFF_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

  typedef enum logic [2:0] {S_IDLE, S_ROT, S_MUL, S_DIV, S_DONE} state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r;
  logic [WB-1:0]    low_r;
  logic [WB-1:0]    high_r;
  logic [EFF_W-1:0] hi_eff_r;
  logic [IW-1:0]    j_r;
  logic             found_r;
  logic [WB-1:0]    q_r;
  logic [WB-1:0]    l0_r;
  logic [WB-1:0]    l1_r;
  logic [EFF_W-1:0] e0_r;
  logic [EFF_W-1:0] e1_r;
  logic [PW-1:0]    prod_r;
  logic [WB-1:0]    den_r;
  logic             neg_r;
  logic             div_start_r;

  logic             out_valid_r;
  logic [EFF_W-1:0] out_eff_r;
  logic             out_below_r;
  logic             out_above_r;
  logic             out_empty_r;
  logic             out_refused_r;
  logic [WB-1:0]    out_low_r;
  logic [WB-1:0]    out_high_r;
  logic [CW-1:0]    out_count_r;

  logic [CW-1:0]    count_nxt;
  logic [WB-1:0]    low_nxt;
  logic [WB-1:0]    high_nxt;
  logic [EFF_W-1:0] hi_eff_nxt;
  logic             insert;
  logic             go_rot;
  logic [EFF_W-1:0] res_eff;
  logic             res_below;
  logic             res_above;
  logic             res_empty;
  logic             res_refused;

  logic             in_fire;
  logic             slot_free;
  logic             out_load;
  logic             out_valid_nxt;
  action_t          act;
  cell_ctrl_t       ctrl;

  logic [WB-1:0]    key_a  [MAX_POINTS];
  logic [EFF_W-1:0] eff_a  [MAX_POINTS];
  logic             keep_a [MAX_POINTS];

  logic             hit;
  logic [EFF_W-1:0] mag;
  logic [WB-1:0]    dq;
  logic             div_done;
  logic [QUOT_W-1:0] quot;
  logic [EFF_W:0]   interp;

  assign slot_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && slot_free;
  assign in_fire     = in_if.valid && in_if.ready;
  assign act         = action_t'(in_if.action);

  assign out_load      = (in_fire && !go_rot) || ((state_r == S_DONE) && slot_free);
  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);

  assign ctrl.insert = in_fire && insert;
  assign ctrl.rotate = (state_r == S_ROT);

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic [WB-1:0]    lk;
    logic [EFF_W-1:0] le;
    logic             lkeep;
    if (i == 0) begin : g_head
      assign lk    = '0;
      assign le    = '0;
      assign lkeep = 1'b0;
    end else begin : g_body
      assign lk    = key_a[i-1];
      assign le    = eff_a[i-1];
      assign lkeep = keep_a[i-1];
    end
    plti_cell #(.WB(WB), .CW(CW), .IDX(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .new_key   (in_if.wavelength),
      .new_eff   (in_if.efficiency_in),
      .left_key  (lk),
      .left_eff  (le),
      .left_keep (lkeep),
      .right_key (key_a[(i+1) % MAX_POINTS]),
      .right_eff (eff_a[(i+1) % MAX_POINTS]),
      .key_r     (key_a[i]),
      .eff_r     (eff_a[i]),
      .keep      (keep_a[i])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    hi_eff_nxt  = hi_eff_r;
    insert      = 1'b0;
    go_rot      = 1'b0;
    res_eff     = '0;
    res_below   = 1'b0;
    res_above   = 1'b0;
    res_empty   = 1'b0;
    res_refused = 1'b0;
    unique case (act)
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      ACT_LOAD: begin
        if (count_r == FULL) begin
          res_refused = 1'b1;
        end else begin
          insert    = 1'b1;
          count_nxt = count_r + CW'(1);
          if (count_r == '0) begin
            low_nxt    = in_if.wavelength;
            high_nxt   = in_if.wavelength;
            hi_eff_nxt = in_if.efficiency_in;
          end else begin
            if (in_if.wavelength < low_r) begin
              low_nxt = in_if.wavelength;
            end
            if (in_if.wavelength >= high_r) begin
              high_nxt   = in_if.wavelength;
              hi_eff_nxt = in_if.efficiency_in;
            end
          end
        end
      end
      ACT_QUERY: begin
        if (count_r == '0) begin
          res_empty = 1'b1;
        end else begin
          res_below = (in_if.wavelength <= low_r);
          res_above = (in_if.wavelength >= high_r);
          if (res_below) begin
            res_eff = eff_a[0];
          end else if (res_above) begin
            res_eff = hi_eff_r;
          end else begin
            go_rot = 1'b1;
          end
        end
      end
      ACT_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Cell 0 holds original entry j_r and cell 1 entry j_r + 1 during the rotation.
  assign hit    = !found_r && ((CW'(j_r) + CW'(1)) < count_r) && (key_a[1] >= q_r);
  assign mag    = (e1_r < e0_r) ? (e0_r - e1_r) : (e1_r - e0_r);
  assign dq     = q_r - l0_r;
  assign interp = neg_r ? ({1'b0, e0_r} - {1'b0, quot}) : ({1'b0, e0_r} + {1'b0, quot});

  plti_div #(.WB(WB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .prod  (prod_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      found_r     <= 1'b0;
      j_r         <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      div_start_r <= (state_r == S_MUL);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            count_r  <= count_nxt;
            low_r    <= low_nxt;
            high_r   <= high_nxt;
            hi_eff_r <= hi_eff_nxt;
            if (go_rot) begin
              state_r <= S_ROT;
              q_r     <= in_if.wavelength;
              j_r     <= '0;
              found_r <= 1'b0;
            end else begin
              out_eff_r     <= res_eff;
              out_below_r   <= res_below;
              out_above_r   <= res_above;
              out_empty_r   <= res_empty;
              out_refused_r <= res_refused;
              out_low_r     <= (count_nxt == '0) ? '0 : low_nxt;
              out_high_r    <= (count_nxt == '0) ? '0 : high_nxt;
              out_count_r   <= count_nxt;
            end
          end
        end
        S_ROT: begin
          if (hit) begin
            found_r <= 1'b1;
            l0_r    <= key_a[0];
            e0_r    <= eff_a[0];
            l1_r    <= key_a[1];
            e1_r    <= eff_a[1];
          end
          j_r <= j_r + IW'(1);
          if (j_r == IW'(MAX_POINTS - 1)) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PW'(dq) * PW'(mag);
          den_r   <= l1_r - l0_r;
          neg_r   <= (e1_r < e0_r);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_eff_r     <= interp[EFF_W-1:0];
            out_below_r   <= 1'b0;
            out_above_r   <= 1'b0;
            out_empty_r   <= 1'b0;
            out_refused_r <= 1'b0;
            out_low_r     <= low_r;
            out_high_r    <= high_r;
            out_count_r   <= count_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.efficiency_out     = out_eff_r;
  assign out_if.below_range        = out_below_r;
  assign out_if.above_range        = out_above_r;
  assign out_if.table_empty        = out_empty_r;
  assign out_if.load_refused       = out_refused_r;
  assign out_if.lowest_wavelength  = out_low_r;
  assign out_if.highest_wavelength = out_high_r;
  assign out_if.point_count        = out_count_r;

endmodule

>>> hdl/plti_check.sv
// Port-level checks on the result beats of the table interpolator, bound to its top level.
// Depends on plti_pkg for the efficiency width.
module plti_check import plti_pkg::*; #(
  parameter int WB  = 16,
  parameter int CW  = 7,
  parameter int MAX = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic [EFF_W-1:0] efficiency_out,
  input logic             below_range,
  input logic             above_range,
  input logic             table_empty,
  input logic             load_refused,
  input logic [WB-1:0]    lowest_wavelength,
  input logic [WB-1:0]    highest_wavelength,
  input logic [CW-1:0]    point_count
);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> point_count <= CW'(MAX))
    else $error("point count above table depth");

  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && load_refused |-> point_count == CW'(MAX) && !table_empty)
    else $error("load refused while table not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_empty |->
      point_count == '0 && efficiency_out == '0 && !below_range && !above_range)
    else $error("empty-table beat carries data");

  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && point_count == '0 |-> lowest_wavelength == '0 && highest_wavelength == '0)
    else $error("range reported for an empty table");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && point_count != '0 |-> lowest_wavelength <= highest_wavelength)
    else $error("lowest wavelength above highest");

endmodule

bind piecewise_linear_table_interp_top plti_check #(
  .WB  (WAVELENGTH_BITS),
  .CW  ($clog2(MAX_POINTS + 1)),
  .MAX (MAX_POINTS)
) u_plti_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .efficiency_out     (out_if.efficiency_out),
  .below_range        (out_if.below_range),
  .above_range        (out_if.above_range),
  .table_empty        (out_if.table_empty),
  .load_refused       (out_if.load_refused),
  .lowest_wavelength  (out_if.lowest_wavelength),
  .highest_wavelength (out_if.highest_wavelength),
  .point_count        (out_if.point_count)
);

>>> dv/tb_piecewise_linear_table_interp_top.sv
// Self-checking testbench for piecewise_linear_table_interp_top: loads, clears and queries the
// point table, predicts every result beat, and compares each one field by field.
// Depends on plti_pkg, plti_if and the RTL of the top level.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interp_top;
  import plti_pkg::*;

  localparam int MAX_POINTS  = 64;
  localparam int WL_W        = 16;
  localparam int CNT_W       = 7;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 400;

  typedef struct packed {
    action_t          action;
    logic [WL_W-1:0]  wavelength;
    logic [EFF_W-1:0] efficiency_in;
  } beat_t;

  typedef struct packed {
    logic [EFF_W-1:0] efficiency_out;
    logic             below_range;
    logic             above_range;
    logic             table_empty;
    logic             load_refused;
    logic [WL_W-1:0]  lowest_wavelength;
    logic [WL_W-1:0]  highest_wavelength;
    logic [CNT_W-1:0] point_count;
  } result_t;

  typedef struct packed {
    beat_t   beat;
    logic    typed;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  plti_in_if  #(.WB(WL_W))              in_ch ();
  plti_out_if #(.WB(WL_W), .CW(CNT_W))  out_ch ();

  piecewise_linear_table_interp_top #(
    .MAX_POINTS      (MAX_POINTS),
    .WAVELENGTH_BITS (WL_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [WL_W-1:0]  pt_wl [MAX_POINTS];
  logic [EFF_W-1:0] pt_eff [MAX_POINTS];
  int               pt_count = 0;

  result_t pending_results [$];
  int      mismatches = 0;
  int      beats_sent = 0;
  int      quiet_cycles = 0;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;
  bit      hold_req = 1'b0;

  function automatic result_t interp_table_step(input beat_t b);
    result_t r;
    int      pos;
    int      k;
    longint  l0, l1, e0, e1;
    r = '0;
    case (b.action)
      ACT_CLEAR: pt_count = 0;
      ACT_LOAD: begin
        if (pt_count >= MAX_POINTS) begin
          r.load_refused = 1'b1;
        end else begin
          pos = 0;
          while (pos < pt_count && pt_wl[pos] <= b.wavelength) pos++;
          for (k = pt_count; k > pos; k--) begin
            pt_wl[k]  = pt_wl[k-1];
            pt_eff[k] = pt_eff[k-1];
          end
          pt_wl[pos]  = b.wavelength;
          pt_eff[pos] = b.efficiency_in;
          pt_count++;
        end
      end
      ACT_QUERY: begin
        if (pt_count == 0) begin
          r.table_empty = 1'b1;
        end else begin
          r.below_range = (b.wavelength <= pt_wl[0]);
          r.above_range = (b.wavelength >= pt_wl[pt_count-1]);
          if (r.below_range) begin
            r.efficiency_out = pt_eff[0];
          end else if (r.above_range) begin
            r.efficiency_out = pt_eff[pt_count-1];
          end else begin
            k = 1;
            while (pt_wl[k] < b.wavelength) k++;
            l0 = pt_wl[k-1];
            l1 = pt_wl[k];
            e0 = pt_eff[k-1];
            e1 = pt_eff[k];
            r.efficiency_out =
              EFF_W'(e0 + (longint'(b.wavelength) - l0) * (e1 - e0) / (l1 - l0));
          end
        end
      end
      default: ;
    endcase
    if (pt_count > 0) begin
      r.lowest_wavelength  = pt_wl[0];
      r.highest_wavelength = pt_wl[pt_count-1];
    end
    r.point_count = CNT_W'(pt_count);
    return r;
  endfunction

  function automatic beat_t pack_beat(input action_t a, input logic [WL_W-1:0] w,
                                      input logic [EFF_W-1:0] e);
    beat_t b;
    b.action        = a;
    b.wavelength    = w;
    b.efficiency_in = e;
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input beat_t b, input bit use_typed = 1'b0,
                           input result_t typed_want = '0);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= b.action;
    in_ch.wavelength    <= b.wavelength;
    in_ch.efficiency_in <= b.efficiency_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = interp_table_step(b);
    pending_results.insert(pending_results.size(), use_typed ? typed_want : predicted);
    if (b.action != ACT_NOP) beats_sent++;
    @(negedge clk);
  endtask

  task automatic run_episode(input bit fill);
    int               n_load;
    int               n_query;
    int               band;
    int               pick;
    int               i;
    logic [WL_W-1:0]  base;
    logic [WL_W-1:0]  w;
    logic [EFF_W-1:0] e;
    if ($urandom_range(99) < 85)
      send_beat(pack_beat(ACT_CLEAR, WL_W'($urandom), EFF_W'($urandom)));
    pick = $urandom_range(99);
    if (fill)           n_load = MAX_POINTS + 6;
    else if (pick < 70) n_load = $urandom_range(2, 10);
    else if (pick < 90) n_load = $urandom_range(11, 40);
    else                n_load = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 4);
    band = $urandom_range(2);
    base = WL_W'($urandom);
    for (i = 0; i < n_load; i++) begin
      case (band)
        0:       w = WL_W'($urandom);
        1:       w = base + WL_W'($urandom_range(255));
        default: w = WL_W'($urandom_range(7)) << 13;
      endcase
      e = ($urandom_range(99) < 85) ? EFF_W'($urandom_range(25600)) : EFF_W'($urandom);
      send_beat(pack_beat(ACT_LOAD, w, e));
      pick = $urandom_range(99);
      if (pick < 4)
        send_beat(pack_beat(ACT_NOP, WL_W'($urandom), EFF_W'($urandom)));
      else if (pick < 8)
        send_beat(pack_beat(ACT_QUERY, WL_W'($urandom), EFF_W'($urandom)));
    end
    n_query = $urandom_range(4, 16);
    for (i = 0; i < n_query; i++) begin
      pick = $urandom_range(99);
      if (pt_count == 0 || pick < 20) w = WL_W'($urandom);
      else if (pick < 35)             w = pt_wl[$urandom_range(pt_count - 1)];
      else                            w = WL_W'($urandom_range(pt_wl[pt_count-1], pt_wl[0]));
      send_beat(pack_beat(ACT_QUERY, w, EFF_W'($urandom)));
    end
    if ($urandom_range(99) < 8) begin
      send_beat(pack_beat(ACT_CLEAR, WL_W'($urandom), EFF_W'($urandom)));
      send_beat(pack_beat(ACT_QUERY, WL_W'($urandom), EFF_W'($urandom)));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    row_t dir_rows [$];
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACT_NOP;
    in_ch.wavelength    <= '0;
    in_ch.efficiency_in <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd0, 15'd0}, 1'b1,
                    '{15'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 7'd0}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_NOP, 16'hFFFF, 15'h7FFF}, 1'b1, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_CLEAR, 16'h1234, 15'h0}, 1'b1, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_LOAD, 16'd1600, 15'd0}, 1'b1,
                    '{15'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1600, 16'd1600, 7'd1}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd1600, 15'd0}, 1'b1,
                    '{15'd0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd1600, 16'd1600, 7'd1}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd0, 15'd0}, 1'b1,
                    '{15'd0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd1600, 16'd1600, 7'd1}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_LOAD, 16'hFFFF, 15'd25600}, 1'b1,
                    '{15'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1600, 16'hFFFF, 7'd2}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_LOAD, 16'd0, 15'h7FFF}, 1'b1,
                    '{15'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'hFFFF, 7'd3}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd0, 15'd0}, 1'b1,
                    '{15'h7FFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 16'hFFFF, 7'd3}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'hFFFF, 15'd0}, 1'b1,
                    '{15'd25600, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'hFFFF, 7'd3}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd800, 15'h7FFF}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd1, 15'd0}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'hFFFE, 15'd0}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd30000, 15'd0}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_LOAD, 16'd1600, 15'd12800}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd1600, 15'd0}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd1601, 15'd0}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_LOAD, 16'd0, 15'd100}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'd0, 15'd0}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_NOP, 16'd0, 15'd0}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_CLEAR, 16'd0, 15'd0}, 1'b1, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'h8000, 15'd0}, 1'b1,
                    '{15'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 7'd0}});
    dir_rows.insert(dir_rows.size(), '{'{ACT_LOAD, 16'h5555, 15'h2AAA}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_LOAD, 16'hAAAA, 15'h5555}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), '{'{ACT_QUERY, 16'h8000, 15'd0}, 1'b0, '0});

    src_idle_pct = 22;
    snk_idle_pct = 50;
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 50 : 0;
      snk_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 22 : 0;
      if (ph == 2) hold_req = 1'b1;
      run_episode(1'b1);
      while (beats_sent < (ph + 1) * PHASE_BEATS + 25) run_episode(1'b0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (MAX_POINTS + 25) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_piecewise_linear_table_interp_top passed");
    end else begin
      $display("tb_piecewise_linear_table_interp_top failed");
    end
    $finish;
  end

  // The long hold lets the result register fill while the sender keeps offering beats.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.efficiency_out, out_ch.below_range, out_ch.above_range,
              out_ch.table_empty, out_ch.load_refused, out_ch.lowest_wavelength,
              out_ch.highest_wavelength, out_ch.point_count};
      if (pending_results.size() == 0) begin
        $error("Result beat arrived with no beat outstanding.");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("efficiency_out", want.efficiency_out, got.efficiency_out);
        check_field("below_range", want.below_range, got.below_range);
        check_field("above_range", want.above_range, got.above_range);
        check_field("table_empty", want.table_empty, got.table_empty);
        check_field("load_refused", want.load_refused, got.load_refused);
        check_field("lowest_wavelength", want.lowest_wavelength, got.lowest_wavelength);
        check_field("highest_wavelength", want.highest_wavelength, got.highest_wavelength);
        check_field("point_count", want.point_count, got.point_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_piecewise_linear_table_interp_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> files.f
hdl/plti_pkg.sv
hdl/plti_if.sv
hdl/plti_cell.sv
hdl/plti_div.sv
hdl/piecewise_linear_table_interp_top.sv
hdl/plti_check.sv
dv/tb_piecewise_linear_table_interp_top.sv
